@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NXT_ND(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/bafg_pkg.sv @@
// Shared types, codes and frame-building functions of the beacon frame generator.
package bafg_pkg;

   localparam int AD_MAX = 31;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_STOP  = 2'd2;

   localparam logic [1:0] CSR_FORMAT   = 2'd0;
   localparam logic [1:0] CSR_DEVICE   = 2'd1;
   localparam logic [1:0] CSR_INTERVAL = 2'd2;
   localparam logic [1:0] CSR_MAX_DUR  = 2'd3;

   localparam logic [2:0] FMT_NAME = 3'd0;
   localparam logic [2:0] FMT_PROX = 3'd1;
   localparam logic [2:0] FMT_UID  = 3'd2;
   localparam logic [2:0] FMT_URL  = 3'd3;
   localparam logic [2:0] FMT_ALT  = 3'd4;
   localparam logic [2:0] FMT_PAIR = 3'd5;
   localparam logic [2:0] FMT_FIND = 3'd6;
   localparam logic [2:0] FMT_NONE = 3'd7;

   localparam logic [15:0] INTERVAL_MIN   = 16'd20;
   localparam logic [15:0] INTERVAL_RESET = 16'd100;
   localparam logic [31:0] MAX_DUR_RESET  = 32'd60000;

   localparam logic [5:0] CHAN_BASE  = 6'd37;
   localparam logic [1:0] SLOT_LAST  = 2'd2;

   localparam logic [7:0] PDU_HEADER = 8'h42;
   localparam logic [7:0] ADDR_TYPE  = 8'hC0;
   localparam logic [7:0] ADDR_MASK  = 8'h3F;
   localparam logic [7:0] TYPE_FLAGS = 8'h01;
   localparam logic [7:0] TYPE_NAME  = 8'h09;
   localparam logic [7:0] TYPE_SVC   = 8'h16;
   localparam logic [7:0] TYPE_MFR   = 8'hFF;
   localparam logic [7:0] FLAGS_VAL  = 8'h06;
   localparam logic [7:0] FLAGS_LEN1 = 8'h02;
   localparam logic [5:0] FLAGS_LEN  = 6'd3;
   localparam logic [5:0] HDR_LEN    = 6'd6;
   localparam logic [5:0] PREFIX_LEN = 6'd8;
   localparam logic [5:0] VAL_START  = 6'd13;

   // Leading four value bytes of each format but the name, first byte in the low bits.
   localparam logic [31:0] PROX_HDR = 32'h1502004C;
   localparam logic [31:0] UID_HDR  = 32'hEE00FEAA;
   localparam logic [31:0] URL_HDR  = 32'hEE10FEAA;
   localparam logic [31:0] ALT_HDR  = 32'hACBEBEAC;
   localparam logic [31:0] PAIR_HDR = 32'h00030006;
   localparam logic [31:0] FIND_HDR = 32'h1612004C;

   localparam logic [7:0] NAME_BYTES [12] = '{
      8'h50, 8'h49, 8'h58, 8'h4C, 8'h41, 8'h4E,
      8'h41, 8'h4C, 8'h59, 8'h5A, 8'h45, 8'h52};
   localparam logic [7:0] URL_BYTES [7] = '{
      8'h70, 8'h69, 8'h78, 8'h6C, 8'h2E, 8'h6A, 8'h73};

   typedef struct packed {
      logic [1:0] slot;
      logic [2:0] fmt;
   } job_type;

   function automatic logic [7:0] id_byte(input logic [63:0] id, input logic [4:0] k);
      return id[{k[2:0], 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] hdr_byte(input logic [31:0] w, input logic [4:0] j);
      return w[{j[1:0], 3'b000} +: 8];
   endfunction

   function automatic logic [5:0] val_len(input logic [2:0] fmt);
      logic [5:0] n;
      unique case (fmt)
         FMT_NAME: n = 6'd12;
         FMT_PROX: n = 6'd25;
         FMT_UID:  n = 6'd22;
         FMT_URL:  n = 6'd11;
         FMT_ALT:  n = 6'd26;
         FMT_PAIR: n = 6'd7;
         FMT_FIND: n = 6'd26;
         default:  n = 6'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] val_type(input logic [2:0] fmt);
      logic [7:0] t;
      unique case (fmt)
         FMT_NAME:         t = TYPE_NAME;
         FMT_UID, FMT_URL: t = TYPE_SVC;
         default:          t = TYPE_MFR;
      endcase
      return t;
   endfunction

   // AD length: flags always fit; the format structure only if within AD_MAX.
   function automatic logic [5:0] ad_len(input logic [2:0] fmt);
      logic [6:0] with_val;
      with_val = 7'(FLAGS_LEN) + 7'd2 + 7'(val_len(fmt));
      if (with_val <= 7'(AD_MAX)) begin
         return with_val[5:0];
      end
      return FLAGS_LEN;
   endfunction

   function automatic logic [7:0] val_byte(input logic [2:0] fmt, input logic [63:0] id,
                                           input logic [4:0] j);
      logic [7:0] b;
      b = 8'h00;
      unique case (fmt)
         FMT_NAME: begin
            if (j < 5'd12) b = NAME_BYTES[j[3:0]];
         end
         FMT_PROX: begin
            if (j < 5'd4) b = hdr_byte(PROX_HDR, j);
            else if (j < 5'd20) b = id_byte(id, j - 5'd4);
            else if (j < 5'd24) b = id_byte(id, j - 5'd20);
            else b = 8'hC5;
         end
         FMT_UID: begin
            if (j < 5'd4) b = hdr_byte(UID_HDR, j);
            else if (j < 5'd14) b = id_byte(id, j - 5'd4);
            else if (j < 5'd20) b = id_byte(id, j - 5'd10);
         end
         FMT_URL: begin
            if (j < 5'd4) b = hdr_byte(URL_HDR, j);
            else if (j < 5'd11) b = URL_BYTES[3'(j - 5'd4)];
         end
         FMT_ALT: begin
            if (j < 5'd4) b = hdr_byte(ALT_HDR, j);
            else if (j < 5'd24) b = id_byte(id, j - 5'd3);
            else if (j == 5'd24) b = 8'hEE;
         end
         FMT_PAIR: begin
            if (j < 5'd4) b = hdr_byte(PAIR_HDR, j);
            else if (j < 5'd7) b = id_byte(id, j - 5'd4);
         end
         FMT_FIND: begin
            if (j < 5'd4) b = hdr_byte(FIND_HDR, j);
            else if (j < 5'd24) b = id_byte(id, j - 5'd4);
            else if (j == 5'd25) b = 8'h01;
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] pdu_byte(input logic [2:0] fmt, input logic [63:0] id,
                                           input logic [5:0] pos);
      logic [7:0] b;
      logic [4:0] j;
      j = 5'(pos - VAL_START);
      if (pos == 6'd0) b = PDU_HEADER;
      else if (pos == 6'd1) b = {2'b00, HDR_LEN + ad_len(fmt)};
      else if (pos < 6'd7) b = id_byte(id, pos[4:0]);
      else if (pos == 6'd7) b = ADDR_TYPE | (id_byte(id, pos[4:0]) & ADDR_MASK);
      else if (pos == 6'd8) b = FLAGS_LEN1;
      else if (pos == 6'd9) b = TYPE_FLAGS;
      else if (pos == 6'd10) b = FLAGS_VAL;
      else if (pos == 6'd11) b = {2'b00, val_len(fmt) + 6'd1};
      else if (pos == 6'd12) b = val_type(fmt);
      else b = val_byte(fmt, id, j);
      return b;
   endfunction

endpackage

@@ rtl/bafg_queue.sv @@
// Two-entry job queue between the session front end and the byte emitter.
module bafg_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bafg_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output bafg_pkg::job_type head_job
);
   import bafg_pkg::*;

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

@@ rtl/bafg_front.sv @@
// Session front end: takes start, stop and tick items and queues due frames.
module bafg_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_func,
   input  logic [31:0]      req_now_time,
   input  logic [2:0]       cfg_format,
   input  logic [15:0]      cfg_interval,
   input  logic [31:0]      cfg_max_dur,
   input  logic             queue_full,
   output logic             push,
   output bafg_pkg::job_type push_job
);
   import bafg_pkg::*;

   logic        active_ff, active_in;
   logic        started_ff, started_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] next_due_ff, next_due_in;
   logic [1:0]  slot_ff, slot_in;

   logic        take;
   logic [31:0] eff_start, eff_next, run_time, due_diff;

   assign req_ready     = !queue_full;
   assign take          = req_valid && req_ready;
   assign eff_start     = started_ff ? start_ff : req_now_time;
   assign eff_next      = started_ff ? next_due_ff : req_now_time;
   assign run_time      = req_now_time - eff_start;
   assign due_diff      = req_now_time - eff_next;
   assign push_job.slot = slot_ff;
   assign push_job.fmt  = cfg_format;

   always_comb begin
      active_in   = active_ff;
      started_in  = started_ff;
      start_in    = start_ff;
      next_due_in = next_due_ff;
      slot_in     = slot_ff;
      push        = 1'b0;
      if (take) begin
         unique case (req_func)
            FUNC_START: begin
               if (cfg_format != FMT_NONE) begin
                  active_in   = 1'b1;
                  started_in  = 1'b0;
                  start_in    = '0;
                  next_due_in = '0;
                  slot_in     = '0;
               end
            end
            FUNC_STOP: active_in = 1'b0;
            FUNC_TICK: begin
               if (active_ff) begin
                  started_in  = 1'b1;
                  start_in    = eff_start;
                  next_due_in = eff_next;
                  if (run_time >= cfg_max_dur) begin
                     active_in = 1'b0;
                  end else if (!due_diff[31]) begin
                     next_due_in = req_now_time + {16'd0, cfg_interval};
                     if (cfg_format != FMT_NONE) begin
                        push    = 1'b1;
                        slot_in = (slot_ff >= SLOT_LAST) ? 2'd0 : slot_ff + 2'd1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         started_ff  <= 1'b0;
         start_ff    <= '0;
         next_due_ff <= '0;
         slot_ff     <= '0;
      end else begin
         active_ff   <= active_in;
         started_ff  <= started_in;
         start_ff    <= start_in;
         next_due_ff <= next_due_in;
         slot_ff     <= slot_in;
      end
   end

endmodule

@@ rtl/bafg_back.sv @@
// Byte emitter: walks one queued frame into the output register, a byte per cycle unless rsp stalls.
module bafg_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_empty,
   input  bafg_pkg::job_type head_job,
   output logic             pop,
   input  logic [63:0]      cfg_device_id,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [5:0]       rsp_channel_index,
   output logic [5:0]       rsp_byte_position,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_last
);
   import bafg_pkg::*;

   logic       busy_ff, busy_in;
   logic [5:0] pos_ff, pos_in;
   job_type    job_ff, job_in;
   logic       out_valid_ff, out_valid_in;
   logic [5:0] out_chan_ff, out_chan_in;
   logic [5:0] out_pos_ff, out_pos_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;

   logic       advance;
   logic [5:0] frame_total;
   logic       is_last;

   assign advance     = !out_valid_ff || rsp_ready;
   assign frame_total = PREFIX_LEN + ad_len(job_ff.fmt);
   assign is_last     = (pos_ff == frame_total - 6'd1);

   always_comb begin
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      job_in       = job_ff;
      out_valid_in = out_valid_ff;
      out_chan_in  = out_chan_ff;
      out_pos_in   = out_pos_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      pop          = 1'b0;
      if (advance) begin
         out_valid_in = busy_ff;
         if (busy_ff) begin
            out_chan_in = CHAN_BASE + {4'd0, job_ff.slot};
            out_pos_in  = pos_ff;
            out_byte_in = pdu_byte(job_ff.fmt, cfg_device_id, pos_ff);
            out_last_in = is_last;
            pos_in      = pos_ff + 6'd1;
            if (is_last) busy_in = 1'b0;
         end
      end
      if (!busy_ff && !queue_empty) begin
         pop     = 1'b1;
         busy_in = 1'b1;
         job_in  = head_job;
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      job_ff      <= job_in;
      out_chan_ff <= out_chan_in;
      out_pos_ff  <= out_pos_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_channel_index = out_chan_ff;
   assign rsp_byte_position = out_pos_ff;
   assign rsp_frame_byte    = out_byte_ff;
   assign rsp_last          = out_last_ff;

endmodule

@@ rtl/beacon_advertising_frame_generator_core.sv @@
// Top level of the beacon advertising frame generator: registers and the three parts.
//
//   channel  direction  transfer when        payload
//   req      in         req_valid&req_ready  func, now_time
//   rsp      out        rsp_valid&rsp_ready  channel_index, byte_position, frame_byte, last
//   csr      in         csr_wr_en            index, 64-bit data, no read-back
//
// The front end takes one req item per cycle while the two-entry frame queue has room.
// A due tick yields a frame of 20 to 39 bytes, one byte per cycle from the emitter while
// rsp is not stalled; the emitter takes the next queued frame only once it is idle again.
// A stalled rsp holds the output register; the queue lets req keep moving meanwhile.
// Reset is synchronous and clears the session, queue and output valid; registers
// return to format 0, id 0, interval 100 ms, duration 60000 ms.
module beacon_advertising_frame_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_channel_index,
   output logic [5:0]  rsp_byte_position,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wr_data
);
   import bafg_pkg::*;

   logic [2:0]  format_ff;
   logic [63:0] device_id_ff;
   logic [15:0] interval_ff;
   logic [31:0] max_dur_ff;
   logic [15:0] interval_wr;

   logic    push, pop, q_full, q_empty;
   job_type push_job, head_job;

   assign interval_wr = (csr_wr_data[15:0] < INTERVAL_MIN) ? INTERVAL_MIN : csr_wr_data[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= FMT_NAME;
         device_id_ff <= '0;
         interval_ff  <= INTERVAL_RESET;
         max_dur_ff   <= MAX_DUR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FORMAT:   format_ff    <= csr_wr_data[2:0];
            CSR_DEVICE:   device_id_ff <= csr_wr_data;
            CSR_INTERVAL: interval_ff  <= interval_wr;
            CSR_MAX_DUR:  max_dur_ff   <= csr_wr_data[31:0];
            default: ;
         endcase
      end
   end

   bafg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_now_time (req_now_time),
      .cfg_format   (format_ff),
      .cfg_interval (interval_ff),
      .cfg_max_dur  (max_dur_ff),
      .queue_full   (q_full),
      .push         (push),
      .push_job     (push_job)
   );

   bafg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .head_job (head_job)
   );

   bafg_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (q_empty),
      .head_job          (head_job),
      .pop               (pop),
      .cfg_device_id     (device_id_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel_index (rsp_channel_index),
      .rsp_byte_position (rsp_byte_position),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last          (rsp_last)
   );

endmodule

@@ rtl/bafg_checker.sv @@
// Port-level checker for the beacon frame generator, bound to the top level.
`include "assert_macros.svh"

module bafg_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] rsp_channel_index,
   input logic [5:0] rsp_byte_position,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_last
);

   `ASSERT_NXT_ND(a_reset_idle, clock, reset, !rsp_valid)

   `ASSERT_IMP(a_chan_range, clock, reset, rsp_valid, rsp_channel_index == 6'd37 || rsp_channel_index == 6'd38 || rsp_channel_index == 6'd39)

   `ASSERT_IMP(a_first_byte, clock, reset, rsp_valid && rsp_byte_position == 6'd0, rsp_frame_byte == 8'h42 && !rsp_last)

   `ASSERT_NXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_byte_position))

   `ASSERT_NXT(a_byte_seq, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid && rsp_byte_position == $past(rsp_byte_position) + 6'd1 && $stable(rsp_channel_index))

endmodule

bind beacon_advertising_frame_generator_core bafg_checker u_bafg_checker (.*);

@@ bench/tb_top.sv @@
// Self-checking testbench for the beacon advertising frame generator core.
`timescale 1ns / 100ps

module tb_top;
   import bafg_pkg::*;

   localparam logic [1:0]  FUNC_BAD       = 2'd3;
   localparam logic [15:0] IV_FLOOR       = 16'd20;
   localparam logic [5:0]  CHAN_FIRST     = 6'd37;
   localparam logic [7:0]  PDU_NONCONN    = 8'h42;
   localparam logic [7:0]  AD_FLAGS       = 8'h01;
   localparam logic [7:0]  AD_NAME        = 8'h09;
   localparam logic [7:0]  AD_SVC         = 8'h16;
   localparam logic [7:0]  AD_MFR         = 8'hFF;
   localparam int          SETTLE_CYCLES  = 64;
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          HOLD_OFF       = 400;

   localparam logic [7:0] NAME_ASCII [12] = '{
      8'h50, 8'h49, 8'h58, 8'h4C, 8'h41, 8'h4E, 8'h41, 8'h4C, 8'h59, 8'h5A, 8'h45, 8'h52};
   localparam logic [7:0] URL_ASCII [7] = '{
      8'h70, 8'h69, 8'h78, 8'h6C, 8'h2E, 8'h6A, 8'h73};

   typedef struct packed {
      logic [5:0] chan;
      logic [5:0] pos;
      logic [7:0] octet;
      logic       eop;
   } pdu_octet_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_func;
   logic [31:0] req_now_time;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [5:0]  rsp_channel_index;
   logic [5:0]  rsp_byte_position;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [63:0] csr_wr_data;

   // predictor copy of registers and session state
   logic [2:0]  cfg_fmt;
   logic [63:0] cfg_id;
   logic [15:0] cfg_iv;
   logic [31:0] cfg_dur;
   logic        mdl_active;
   logic        mdl_started;
   logic [31:0] mdl_t_start;
   logic [31:0] mdl_t_due;
   logic [1:0]  mdl_slot;

   pdu_octet_type  pdu_bytes_due [$];
   pdu_octet_type  seen;
   pdu_octet_type  want;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int          rsp_hold_left = 0;
   int          idle_cycles = 0;
   int          n_errors = 0;
   int          n_req = 0;
   int          n_bytes = 0;
   int          n_frames = 0;

   beacon_advertising_frame_generator_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_now_time      (req_now_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel_index (rsp_channel_index),
      .rsp_byte_position (rsp_byte_position),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always #4 clock = ~clock;

   function automatic logic [7:0] id_octet(input int k);
      return cfg_id[8 * (k % 8) +: 8];
   endfunction

   function automatic void note_error(input string msg);
      n_errors++;
      if (n_errors <= 10) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
   endfunction

   function automatic void store_reg(input logic [1:0] idx, input logic [63:0] data);
      case (idx)
         CSR_FORMAT:   cfg_fmt = data[2:0];
         CSR_DEVICE:   cfg_id = data;
         CSR_INTERVAL: cfg_iv = (data[15:0] < IV_FLOOR) ? IV_FLOOR : data[15:0];
         CSR_MAX_DUR:  cfg_dur = data[31:0];
         default: ;
      endcase
   endfunction

   function automatic void clear_model();
      cfg_fmt = FMT_NAME;
      cfg_id = '0;
      cfg_iv = 16'd100;
      cfg_dur = 32'd60000;
      mdl_active = 1'b0;
      mdl_started = 1'b0;
      mdl_t_start = '0;
      mdl_t_due = '0;
      mdl_slot = '0;
   endfunction

   // Tick handling: session timing, then the PDU bytes of a due event.
   function automatic void emit_frame_bytes(input logic [31:0] now);
      logic [7:0]  val [26];
      logic [7:0]  pdu [39];
      logic [7:0]  vtype;
      logic [31:0] lead;
      logic [31:0] elapsed;
      int          nval;
      int          ad_n;
      int          total;
      int          i;
      if (!mdl_active) return;
      if (!mdl_started) begin
         mdl_started = 1'b1;
         mdl_t_start = now;
         mdl_t_due = now;
      end
      elapsed = now - mdl_t_start;
      if (elapsed >= cfg_dur) begin
         mdl_active = 1'b0;
         return;
      end
      elapsed = now - mdl_t_due;
      if (elapsed[31]) return;
      mdl_t_due = now + 32'(cfg_iv);

      for (i = 0; i < 26; i++) val[i] = 8'h00;
      lead = '0;
      vtype = AD_MFR;
      case (cfg_fmt)
         FMT_NAME: begin
            for (i = 0; i < 12; i++) val[i] = NAME_ASCII[i];
            nval = 12;
            vtype = AD_NAME;
         end
         FMT_PROX: begin
            lead = {8'h15, 8'h02, 8'h00, 8'h4C};
            for (i = 0; i < 16; i++) val[4 + i] = id_octet(i);
            for (i = 0; i < 4; i++) val[20 + i] = id_octet(i);
            val[24] = 8'hC5;
            nval = 25;
         end
         FMT_UID: begin
            lead = {8'hEE, 8'h00, 8'hFE, 8'hAA};
            for (i = 0; i < 10; i++) val[4 + i] = id_octet(i);
            for (i = 0; i < 6; i++) val[14 + i] = id_octet(i + 4);
            nval = 22;
            vtype = AD_SVC;
         end
         FMT_URL: begin
            lead = {8'hEE, 8'h10, 8'hFE, 8'hAA};
            for (i = 0; i < 7; i++) val[4 + i] = URL_ASCII[i];
            nval = 11;
            vtype = AD_SVC;
         end
         FMT_ALT: begin
            lead = {8'hAC, 8'hBE, 8'hBE, 8'hAC};
            for (i = 0; i < 20; i++) val[4 + i] = id_octet(i + 1);
            val[24] = 8'hEE;
            nval = 26;
         end
         FMT_PAIR: begin
            lead = {8'h00, 8'h03, 8'h00, 8'h06};
            for (i = 0; i < 3; i++) val[4 + i] = id_octet(i);
            nval = 7;
         end
         FMT_FIND: begin
            lead = {8'h16, 8'h12, 8'h00, 8'h4C};
            for (i = 0; i < 20; i++) val[4 + i] = id_octet(i);
            val[25] = 8'h01;
            nval = 26;
         end
         default: return;
      endcase
      if (cfg_fmt != FMT_NAME) begin
         for (i = 0; i < 4; i++) val[i] = lead[8 * i +: 8];
      end

      pdu[8] = 8'h02;
      pdu[9] = AD_FLAGS;
      pdu[10] = 8'h06;
      ad_n = 3;
      if (ad_n + 2 + nval <= AD_MAX) begin
         pdu[8 + ad_n] = 8'(nval + 1);
         pdu[9 + ad_n] = vtype;
         for (i = 0; i < nval; i++) pdu[10 + ad_n + i] = val[i];
         ad_n += 2 + nval;
      end
      pdu[0] = PDU_NONCONN;
      pdu[1] = 8'(6 + ad_n);
      for (i = 0; i < 6; i++) pdu[2 + i] = id_octet(i + 2);
      pdu[7][7:6] = 2'b11;
      total = 8 + ad_n;
      for (i = 0; i < total; i++) begin
         pdu_bytes_due.push_back('{CHAN_FIRST + 6'(mdl_slot), 6'(i), pdu[i], i == total - 1});
      end
      mdl_slot = (mdl_slot >= 2'd2) ? 2'd0 : mdl_slot + 2'd1;
   endfunction

   function automatic void advance_session(input logic [1:0] f, input logic [31:0] now);
      case (f)
         FUNC_START: begin
            if (cfg_fmt != FMT_NONE) begin
               mdl_active = 1'b1;
               mdl_started = 1'b0;
               mdl_t_start = '0;
               mdl_t_due = '0;
               mdl_slot = '0;
            end
         end
         FUNC_STOP: mdl_active = 1'b0;
         FUNC_TICK: emit_frame_bytes(now);
         default: ;
      endcase
   endfunction

   // Called at a falling edge; returns at a falling edge with valid still high.
   task automatic send_item(input logic [1:0] f, input logic [31:0] now);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_now_time <= now;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      advance_session(f, now);
      n_req++;
      @(negedge clock);
   endtask

   task automatic drain_and_wait();
      req_valid <= 1'b0;
      while (pdu_bytes_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      store_reg(idx, data);
      @(negedge clock);
   endtask

   // only after drain_and_wait, so no request is pending
   task automatic set_pacing(input int unsigned send_pct, input int unsigned stall_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      @(negedge clock);
   endtask

   task automatic test_defaults();
      send_item(FUNC_TICK, 32'd0);
      send_item(FUNC_STOP, 32'd5);
      send_item(FUNC_BAD, 32'hFFFF_FFFF);
      send_item(FUNC_START, 32'd0);
      send_item(FUNC_TICK, 32'd0);
      send_item(FUNC_TICK, 32'd99);
      send_item(FUNC_TICK, 32'd100);
   endtask

   task automatic test_formats();
      logic [2:0] f;
      drain_and_wait();
      write_reg(CSR_DEVICE, 64'h0123_4567_89AB_CDEF);
      for (f = FMT_PROX; f <= FMT_FIND; f++) begin
         drain_and_wait();
         write_reg(CSR_FORMAT, {61'd0, f});
         send_item(FUNC_TICK, mdl_t_due);
         if (f == FMT_ALT) begin
            drain_and_wait();
            write_reg(CSR_DEVICE, 64'hFFFF_FFFF_FFFF_FFFF);
         end
      end
      // disabled format: due ticks move the schedule, nothing sent, start ignored
      drain_and_wait();
      write_reg(CSR_FORMAT, {61'd0, FMT_NONE});
      send_item(FUNC_TICK, mdl_t_due);
      send_item(FUNC_START, mdl_t_due);
      drain_and_wait();
      write_reg(CSR_FORMAT, {61'd0, FMT_PAIR});
      send_item(FUNC_TICK, mdl_t_due);
   endtask

   task automatic test_session_limits();
      drain_and_wait();
      write_reg(CSR_INTERVAL, 64'hFFFF_FFFF_FFFF_0003);
      write_reg(CSR_MAX_DUR, 64'hFFFF_FFFF);
      write_reg(CSR_FORMAT, {61'd0, FMT_URL});
      send_item(FUNC_START, 32'd0);
      send_item(FUNC_TICK, 32'hFFFF_FFF0);
      send_item(FUNC_TICK, 32'h0000_0004);
      send_item(FUNC_TICK, mdl_t_due + 32'h8000_0000);
      send_item(FUNC_TICK, mdl_t_due);
      drain_and_wait();
      write_reg(CSR_MAX_DUR, 64'd0);
      send_item(FUNC_START, 32'd0);
      send_item(FUNC_TICK, 32'd77);
      drain_and_wait();
      write_reg(CSR_MAX_DUR, 64'd45);
      send_item(FUNC_START, 32'd0);
      send_item(FUNC_TICK, 32'h0000_1000);
      send_item(FUNC_START, 32'd0);
      send_item(FUNC_TICK, 32'h0000_2000);
      send_item(FUNC_TICK, 32'h0000_2000 + 32'd45);
   endtask

   task automatic configure_random(input int seg);
      logic [63:0] iv_word;
      logic [31:0] dur;
      case ($urandom_range(3))
         0: iv_word = {$urandom, 16'h0, 16'($urandom_range(0, 19))};
         1: iv_word = 64'($urandom_range(20, 200));
         2: iv_word = {$urandom, $urandom};
         default: iv_word = 64'hFFFF;
      endcase
      case ($urandom_range(3))
         0: dur = $urandom_range(1, 300);
         1: dur = $urandom;
         2: dur = 32'hFFFF_FFFF;
         default: dur = 32'd1;
      endcase
      if (seg == 0) begin
         iv_word = 64'hFFFF;
         dur = 32'hFFFF_FFFF;
      end else if (seg == 1) begin
         iv_word = 64'd20;
         dur = $urandom_range(40, 200);
      end
      write_reg(CSR_FORMAT, {$urandom, 29'($urandom), 3'($urandom_range(0, 6))});
      write_reg(CSR_DEVICE, {$urandom, $urandom});
      write_reg(CSR_INTERVAL, iv_word);
      write_reg(CSR_MAX_DUR, {$urandom, dur});
   endtask

   // mostly well-formed sessions with due ticks, some noise
   task automatic send_random_item();
      int unsigned r;
      r = $urandom_range(99);
      if (!mdl_active && r >= 10) send_item(FUNC_START, $urandom);
      else if (r < 4) send_item(FUNC_STOP, $urandom);
      else if (r < 7) send_item(FUNC_BAD, $urandom);
      else if (r < 10) send_item(FUNC_TICK, $urandom);
      else if (r < 13) send_item(FUNC_START, $urandom);
      else if (!mdl_started) send_item(FUNC_TICK, $urandom);
      else if (r < 28) send_item(FUNC_TICK, mdl_t_due - $urandom_range(1, cfg_iv - 1));
      else send_item(FUNC_TICK, mdl_t_due + $urandom_range(0, cfg_iv - 1));
   endtask

   task automatic test_random_traffic();
      int m;
      int seg;
      int k;
      for (m = 0; m < 4; m++) begin
         for (seg = 0; seg < 2; seg++) begin
            drain_and_wait();
            case (m)
               0: set_pacing(0, 0);
               1: set_pacing(45, 0);
               2: set_pacing(0, 45);
               default: set_pacing(8, 8);
            endcase
            configure_random(m * 2 + seg);
            for (k = 0; k < 10; k++) send_random_item();
         end
      end
   endtask

   task automatic test_backpressure();
      int k;
      drain_and_wait();
      set_pacing(0, 0);
      write_reg(CSR_FORMAT, {61'd0, FMT_ALT});
      write_reg(CSR_INTERVAL, 64'd20);
      write_reg(CSR_MAX_DUR, 64'hFFFF_FFFF);
      @(posedge clock);
      rsp_hold_left = HOLD_OFF;
      @(negedge clock);
      send_item(FUNC_START, 32'd0);
      for (k = 0; k < 10; k++) send_item(FUNC_TICK, mdl_t_due + $urandom_range(0, 19));
      drain_and_wait();
      for (k = 0; k < 3; k++) send_item(FUNC_TICK, mdl_t_due);
   endtask

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         seen = '{rsp_channel_index, rsp_byte_position, rsp_frame_byte, rsp_last};
         n_bytes++;
         if (rsp_last === 1'b1) n_frames++;
         if (pdu_bytes_due.size() == 0) begin
            note_error($sformatf("unexpected byte: ch %0d pos %0d byte %02h last %0b",
                                 seen.chan, seen.pos, seen.octet, seen.eop));
         end else begin
            want = pdu_bytes_due.pop_front();
            if (seen.chan !== want.chan || seen.pos !== want.pos ||
                seen.octet !== want.octet || seen.eop !== want.eop) begin
               note_error($sformatf({"expected ch %0d pos %0d byte %02h last %0b, ",
                                     "got ch %0d pos %0d byte %02h last %0b"},
                                    want.chan, want.pos, want.octet, want.eop,
                                    seen.chan, seen.pos, seen.octet, seen.eop));
            end
         end
      end
   end

   // no transfer on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d bytes outstanding",
                  idle_cycles, pdu_bytes_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_TICK;
      req_now_time = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_FORMAT;
      csr_wr_data = '0;
      clear_model();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_defaults();
      test_formats();
      test_session_limits();
      test_random_traffic();
      test_backpressure();
      drain_and_wait();

      $display("Run covered %0d requests and %0d frame bytes in %0d frames,",
               n_req, n_bytes, n_frames);
      $display("all formats, limits, time wrap, four pacing modes and a long output stall.");
      if (n_errors == 0 && pdu_bytes_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
